### rtl/core/backward_lz_bitstream_unpacker_defines.svh
// assertion macros for the backward lz bitstream unpacker
`ifndef BACKWARD_LZ_BITSTREAM_UNPACKER_DEFINES_SVH
`define BACKWARD_LZ_BITSTREAM_UNPACKER_DEFINES_SVH
`ifndef SYNTH
`define BLBU_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define BLBU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BLBU_ASSERT(lbl, cond)
`define BLBU_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

### rtl/core/blbu_pkg.sv
// shared types for the backward lz bitstream unpacker
`default_nettype none
package blbu_pkg;

  typedef struct packed {
    logic        is_hdr;
    logic [7:0]  data;
    logic        boundary;
    logic        acc_zero;
    logic [31:0] size;
    logic [31:0] word;
  } tok_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        final_grp;
    logic        chk;
    logic        bad;
  } res_t;

  localparam int TokW = $bits(tok_t);
  localparam int ResW = $bits(res_t);

endpackage
`default_nettype wire

### rtl/core/blbu_fifo.sv
// small register queue
`default_nettype none
module blbu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/blbu_front.sv
// header parser and check accumulator, hands bytes to the decoder
`default_nettype none
module blbu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_sof,
  output logic              tok_push,
  output blbu_pkg::tok_t    tok
);
  import blbu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HDR  = 3'b010,
    PH_DATA = 3'b100
  } ph_t;

  ph_t         ph_r, ph_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] bb_r, bb_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] bbw, accw;

  always_comb begin
    ph_nxt   = ph_r;
    pos_nxt  = pos_r;
    bb_nxt   = bb_r;
    acc_nxt  = acc_r;
    size_nxt = size_r;
    tok_push = 1'b0;
    tok      = '0;
    bbw      = bb_r | ({24'b0, in_byte} << {pos_r[1:0], 3'b000});
    accw     = acc_r ^ ({24'b0, in_byte} << {pos_r[1:0], 3'b000});
    if (accept) begin
      if (in_sof) begin
        ph_nxt  = PH_HDR;
        pos_nxt = 4'd1;
        bb_nxt  = {24'b0, in_byte};
        acc_nxt = '0;
      end else begin
        unique case (ph_r)
          PH_IDLE: begin
          end
          PH_HDR: begin
            pos_nxt = pos_r + 4'd1;
            bb_nxt  = bbw;
            if (pos_nxt == 4'd4) begin
              size_nxt = bbw;
              bb_nxt   = '0;
            end else if (pos_nxt == 4'd8) begin
              acc_nxt = bbw;
              bb_nxt  = '0;
            end else if (pos_nxt == 4'd12) begin
              acc_nxt      = acc_r ^ bbw;
              bb_nxt       = '0;
              ph_nxt       = PH_DATA;
              pos_nxt      = '0;
              tok_push     = 1'b1;
              tok.is_hdr   = 1'b1;
              tok.size     = size_r;
              tok.word     = bbw;
              tok.boundary = 1'b1;
              tok.acc_zero = ((acc_r ^ bbw) == '0);
            end
          end
          PH_DATA: begin
            acc_nxt      = accw;
            pos_nxt      = {2'b00, pos_r[1:0] + 2'd1};
            tok_push     = 1'b1;
            tok.data     = in_byte;
            tok.boundary = (pos_r[1:0] == 2'd3);
            tok.acc_zero = (accw == '0);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      pos_r  <= '0;
      bb_r   <= '0;
      acc_r  <= '0;
      size_r <= '0;
    end else begin
      ph_r   <= ph_nxt;
      pos_r  <= pos_nxt;
      bb_r   <= bb_nxt;
      acc_r  <= acc_nxt;
      size_r <= size_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/core/blbu_back.sv
// bit decoder, copy engine, history window and byte packer
`default_nettype none
module blbu_back #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int GROUP_BYTES  = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           tok_empty,
  input  wire blbu_pkg::tok_t tok,
  output logic                tok_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output blbu_pkg::res_t      res
);
  import blbu_pkg::*;

  localparam int HPW = $clog2(WINDOW_DEPTH);
  localparam int BWW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [4:0] {
    S_TOKEN = 5'b00001,
    S_FEED  = 5'b00010,
    S_CRD   = 5'b00100,
    S_CWR   = 5'b01000,
    S_FIN   = 5'b10000
  } st_t;

  typedef enum logic [2:0] {
    TK_P0 = 3'b001,
    TK_P1 = 3'b010,
    TK_FD = 3'b100
  } tk_t;

  typedef enum logic [2:0] {
    FD_SEL, FD_LIT3, FD_LIT8, FD_CLEN, FD_OFF, FD_LIT
  } fd_t;

  st_t         st_r, st_nxt;
  tk_t         tk_r, tk_nxt;
  fd_t         fd_r, fd_nxt;
  logic        running_r, running_nxt;
  logic        active_r, active_nxt;
  logic        bad_r, bad_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [11:0] fs_r, fs_nxt;
  logic [3:0]  fl_r, fl_nxt;
  logic [8:0]  rl_r, rl_nxt;
  logic [HPW-1:0] hp_r, hp_nxt;
  logic [BWW-1:0] bw_r, bw_nxt;
  logic [63:0] buf_r, buf_nxt, buf_base;
  logic [3:0]  fill_r, fill_nxt, fill_base;
  logic [31:0] sr_r, sr_nxt;
  logic        bnd_r, bnd_nxt;
  logic        accz_r, accz_nxt;
  logic [11:0] off_r, off_nxt;
  logic [8:0]  cl_r, cl_nxt;
  logic        valid_r, valid_nxt;

  logic [7:0]     mem_r [WINDOW_DEPTH];
  logic [7:0]     rdata_r;
  logic           re;
  logic [HPW-1:0] raddr;
  logic [HPW:0]   offx;

  logic        do_emit;
  logic [7:0]  emit_v;
  logic        b;
  logic [11:0] c;
  logic [3:0]  fl_dec;
  logic        run_set;
  logic [8:0]  run_cnt;
  logic        off_ok;

  always_ff @(posedge clk) begin
    if (do_emit) begin
      mem_r[hp_r] <= emit_v;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  always_comb begin
    offx   = {{(HPW + 1 - 12){1'b0}}, off_r};
    off_ok = (off_r != '0) && (32'(off_r) <= 32'(bw_r)) &&
             (32'(off_r) < 32'(WINDOW_DEPTH));
    if ({1'b0, hp_r} >= offx) begin
      raddr = HPW'({1'b0, hp_r} - offx);
    end else begin
      raddr = HPW'({1'b0, hp_r} + (HPW + 1)'(WINDOW_DEPTH) - offx);
    end
  end

  always_comb begin
    st_nxt      = st_r;
    tk_nxt      = tk_r;
    fd_nxt      = fd_r;
    running_nxt = running_r;
    active_nxt  = active_r;
    bad_nxt     = bad_r;
    rem_nxt     = rem_r;
    fs_nxt      = fs_r;
    fl_nxt      = fl_r;
    rl_nxt      = rl_r;
    hp_nxt      = hp_r;
    bw_nxt      = bw_r;
    buf_nxt     = buf_r;
    fill_nxt    = fill_r;
    sr_nxt      = sr_r;
    bnd_nxt     = bnd_r;
    accz_nxt    = accz_r;
    off_nxt     = off_r;
    cl_nxt      = cl_r;
    valid_nxt   = valid_r;
    tok_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    re          = 1'b0;
    do_emit     = 1'b0;
    emit_v      = '0;
    run_set     = 1'b0;
    run_cnt     = '0;
    buf_base    = buf_r;
    fill_base   = fill_r;
    b           = sr_r[0];
    c           = {fs_r[10:0], sr_r[0]};
    fl_dec      = fl_r - 4'd1;

    unique case (st_r)
      S_TOKEN: begin
        if (!tok_empty) begin
          tok_pop  = 1'b1;
          bnd_nxt  = tok.boundary;
          accz_nxt = tok.acc_zero;
          if (tok.is_hdr) begin
            running_nxt = 1'b1;
            rem_nxt     = tok.size;
            active_nxt  = (tok.size != '0);
            bad_nxt     = (tok.size == '0);
            tk_nxt      = TK_P0;
            fs_nxt      = '0;
            fl_nxt      = '0;
            fd_nxt      = FD_SEL;
            rl_nxt      = '0;
            hp_nxt      = '0;
            bw_nxt      = '0;
            buf_nxt     = '0;
            fill_nxt    = '0;
            sr_nxt      = tok.word;
            st_nxt      = S_FEED;
          end else begin
            sr_nxt = {23'b0, 1'b1, tok.data};
            if (running_r) begin
              st_nxt = S_FEED;
            end
          end
        end
      end
      S_FEED: begin
        if (!res_full) begin
          if (active_r && (sr_r[31:1] != '0)) begin
            sr_nxt = {1'b0, sr_r[31:1]};
            unique case (tk_r)
              TK_P0: begin
                if (b) begin
                  fs_nxt = '0; fl_nxt = 4'd2; fd_nxt = FD_SEL; tk_nxt = TK_FD;
                end else begin
                  tk_nxt = TK_P1;
                end
              end
              TK_P1: begin
                tk_nxt = TK_FD;
                fs_nxt = '0;
                if (b) begin
                  run_set = 1'b1; run_cnt = 9'd2;
                  fl_nxt = 4'd8; fd_nxt = FD_OFF;
                end else begin
                  fl_nxt = 4'd3; fd_nxt = FD_LIT3;
                end
              end
              TK_FD: begin
                fs_nxt = c;
                fl_nxt = fl_dec;
                if (fl_dec == '0) begin
                  fs_nxt = '0;
                  unique case (fd_r)
                    FD_SEL: begin
                      if (c == 12'd3) begin
                        fl_nxt = 4'd8; fd_nxt = FD_LIT8;
                      end else if (c < 12'd2) begin
                        run_set = 1'b1; run_cnt = 9'(c) + 9'd3;
                        fl_nxt = 4'(c) + 4'd9; fd_nxt = FD_OFF;
                      end else begin
                        fl_nxt = 4'd8; fd_nxt = FD_CLEN;
                      end
                    end
                    FD_LIT3: begin
                      run_set = 1'b1; run_cnt = 9'(c) + 9'd1;
                      fl_nxt = 4'd8; fd_nxt = FD_LIT;
                    end
                    FD_LIT8: begin
                      run_set = 1'b1; run_cnt = 9'(c) + 9'd9;
                      fl_nxt = 4'd8; fd_nxt = FD_LIT;
                    end
                    FD_CLEN: begin
                      run_set = 1'b1; run_cnt = 9'(c) + 9'd1;
                      fl_nxt = 4'd12; fd_nxt = FD_OFF;
                    end
                    FD_OFF: begin
                      off_nxt = c;
                      cl_nxt  = rl_r;
                      st_nxt  = S_CRD;
                    end
                    FD_LIT: begin
                      do_emit = 1'b1;
                      emit_v  = c[7:0];
                      if (rl_r != '0) begin
                        rl_nxt = rl_r - 9'd1;
                      end
                      if (rl_nxt == '0) begin
                        tk_nxt = TK_P0;
                      end else begin
                        fl_nxt = 4'd8; fd_nxt = FD_LIT;
                      end
                    end
                    default: begin
                    end
                  endcase
                end
              end
              default: begin
              end
            endcase
          end else if (!active_r && bnd_r) begin
            st_nxt = S_FIN;
          end else begin
            st_nxt = S_TOKEN;
          end
        end
      end
      S_CRD: begin
        if ((cl_r != '0) && active_r) begin
          re        = 1'b1;
          valid_nxt = off_ok;
          st_nxt    = S_CWR;
        end else begin
          tk_nxt = TK_P0;
          st_nxt = S_FEED;
        end
      end
      S_CWR: begin
        if (!res_full) begin
          do_emit = 1'b1;
          emit_v  = valid_r ? rdata_r : 8'd0;
          if (!valid_r) begin
            bad_nxt = 1'b1;
          end
          cl_nxt = cl_r - 9'd1;
          st_nxt = S_CRD;
        end
      end
      S_FIN: begin
        if (!res_full) begin
          res_push      = 1'b1;
          res.bytes     = buf_r;
          res.count     = fill_r;
          res.final_grp = 1'b1;
          res.chk       = accz_r;
          res.bad       = bad_r;
          running_nxt   = 1'b0;
          st_nxt        = S_TOKEN;
        end
      end
      default: begin
        st_nxt = S_TOKEN;
      end
    endcase

    if (run_set) begin
      rl_nxt = run_cnt;
      if ({23'b0, run_cnt} > rem_r) begin
        bad_nxt = 1'b1;
      end
    end

    if (do_emit) begin
      hp_nxt = (hp_r == HPW'(WINDOW_DEPTH - 1)) ? '0 : hp_r + 1'b1;
      if (bw_r < BWW'(WINDOW_DEPTH)) begin
        bw_nxt = bw_r + 1'b1;
      end
      if (32'(fill_r) >= 32'(GROUP_BYTES)) begin
        res_push      = 1'b1;
        res.bytes     = buf_r;
        res.count     = fill_r;
        res.final_grp = 1'b0;
        res.chk       = 1'b0;
        res.bad       = bad_nxt;
        buf_base      = '0;
        fill_base     = '0;
      end
      buf_nxt  = buf_base | ({56'b0, emit_v} << {fill_base[2:0], 3'b000});
      fill_nxt = fill_base + 4'd1;
      if (rem_r != '0) begin
        rem_nxt = rem_r - 32'd1;
      end
      if (rem_nxt == '0) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_TOKEN;
      tk_r      <= TK_P0;
      fd_r      <= FD_SEL;
      running_r <= 1'b0;
      active_r  <= 1'b0;
      bad_r     <= 1'b0;
      rem_r     <= '0;
      fs_r      <= '0;
      fl_r      <= '0;
      rl_r      <= '0;
      hp_r      <= '0;
      bw_r      <= '0;
      buf_r     <= '0;
      fill_r    <= '0;
      cl_r      <= '0;
    end else begin
      st_r      <= st_nxt;
      tk_r      <= tk_nxt;
      fd_r      <= fd_nxt;
      running_r <= running_nxt;
      active_r  <= active_nxt;
      bad_r     <= bad_nxt;
      rem_r     <= rem_nxt;
      fs_r      <= fs_nxt;
      fl_r      <= fl_nxt;
      rl_r      <= rl_nxt;
      hp_r      <= hp_nxt;
      bw_r      <= bw_nxt;
      buf_r     <= buf_nxt;
      fill_r    <= fill_nxt;
      cl_r      <= cl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r    <= sr_nxt;
    bnd_r   <= bnd_nxt;
    accz_r  <= accz_nxt;
    off_r   <= off_nxt;
    valid_r <= valid_nxt;
  end
endmodule
`default_nettype wire

### rtl/core/backward_lz_bitstream_unpacker.sv
// Backward LZ bitstream unpacker. Packed bytes are pushed from the file's
// last byte toward its first, start_of_file set on the first one pushed.
// A front stage parses the 12-byte header and keeps the check XOR; it takes
// one byte per cycle while its 4-entry queue to the decoder has room. The
// decoder reads one stream bit per cycle while the result queue has room
// and no copy is under way; a data byte is popped from the queue, its eight
// bits are decoded, and the decoder then sees it used up; a literal byte is
// produced in the cycle of its last bit, and a copied byte takes a history
// read, then a write, plus a pass through the read state to leave each copy.
// Results leave in groups of GROUP_BYTES through a 4-entry queue; the final
// group carries the check outcome. The history window needs no clearing
// after reset.
`default_nettype none
module backward_lz_bitstream_unpacker #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int GROUP_BYTES  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_packed_byte,
  input  wire logic        in_start_of_file,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      out_bytes,
  output logic [3:0]       out_byte_count,
  output logic             out_final_group,
  output logic             out_check_ok,
  output logic             out_malformed
);
  import blbu_pkg::*;
  `include "backward_lz_bitstream_unpacker_defines.svh"

  logic          tok_push, tok_full, tok_empty, tok_pop;
  tok_t          tok_in, tok_out;
  logic [TokW-1:0] tok_raw;
  logic          res_push, res_full;
  res_t          res_in, res_out;
  logic [ResW-1:0] res_raw;

  assign full = tok_full;

  blbu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (push && !tok_full),
    .in_byte  (in_packed_byte),
    .in_sof   (in_start_of_file),
    .tok_push (tok_push),
    .tok      (tok_in)
  );

  blbu_fifo #(.WIDTH(TokW), .DEPTH(4)) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tok_push),
    .wdata (tok_in),
    .full  (tok_full),
    .pop   (tok_pop),
    .rdata (tok_raw),
    .empty (tok_empty)
  );

  assign tok_out = tok_t'(tok_raw);

  blbu_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .GROUP_BYTES(GROUP_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_empty (tok_empty),
    .tok       (tok_out),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  blbu_fifo #(.WIDTH(ResW), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_raw),
    .empty (empty)
  );

  assign res_out         = res_t'(res_raw);
  assign out_bytes       = res_out.bytes;
  assign out_byte_count  = res_out.count;
  assign out_final_group = res_out.final_grp;
  assign out_check_ok    = res_out.chk;
  assign out_malformed   = res_out.bad;

  `BLBU_ASSERT_IMPL(a_full_group, !empty && !out_final_group,
                    32'(out_byte_count) == 32'(GROUP_BYTES))
  `BLBU_ASSERT_IMPL(a_empty_final, !empty && out_byte_count == 4'd0,
                    out_final_group && out_malformed)
  `BLBU_ASSERT_IMPL(a_tok_room, tok_push, !tok_full)
  `BLBU_ASSERT_IMPL(a_res_room, res_push, !res_full)
endmodule
`default_nettype wire

### dv/tb_top.sv
// self-checking testbench for the backward lz bitstream unpacker
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import blbu_pkg::*;

  typedef enum int {ST_IDLE, ST_HEADER, ST_DATA, ST_DRAIN} unpack_state_e;
  typedef enum int {TK_PREFIX0, TK_PREFIX1, TK_FIELD} token_state_e;
  typedef enum int {F_SELECT, F_LITCNT3, F_LITCNT8, F_COPYLEN, F_OFFSET, F_LITERAL} field_e;

  localparam int HIST_DEPTH = 4096;
  localparam int STEP_CAP = 33;

  typedef struct {
    bit [7:0] data;
    bit       sof;
    bit       drain_first;
  } packed_item_t;

  logic clk, rst_n, push, full, empty, pop;
  logic [7:0] in_packed_byte;
  logic in_start_of_file;
  logic [63:0] out_bytes;
  logic [3:0] out_byte_count;
  logic out_final_group, out_check_ok, out_malformed;

  backward_lz_bitstream_unpacker uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_packed_byte(in_packed_byte), .in_start_of_file(in_start_of_file),
    .empty(empty), .pop(pop), .out_bytes(out_bytes), .out_byte_count(out_byte_count),
    .out_final_group(out_final_group), .out_check_ok(out_check_ok),
    .out_malformed(out_malformed)
  );

  packed_item_t pending_bytes[$];
  res_t expected_groups[$];
  int issued, accepted, groups_seen, finals_seen, files_built, mismatches;
  int send_gap, pop_gap;
  bit send_burst, pop_burst;

  // unpacker state mirror
  unpack_state_e ustate;
  token_state_e tstate;
  field_e fdest;
  bit [31:0] word_buf, chk_acc, remain;
  int bpos, fleft, run_len, nwritten, pfill, step_n;
  bit [15:0] fshift;
  bit [7:0] hist[HIST_DEPTH];
  bit [11:0] hptr;
  bit [63:0] pack;
  bit live, bad;

  function automatic void push_group(bit fin);
    res_t r;
    if (step_n < STEP_CAP) begin
      r.bytes = pack;
      r.count = pfill[3:0];
      r.final_grp = fin;
      r.chk = fin && (chk_acc == 0);
      r.bad = bad;
      expected_groups.push_back(r);
      step_n++;
    end
    pack = 0;
    pfill = 0;
  endfunction

  function automatic void emit_byte(bit [7:0] v);
    hist[hptr] = v;
    hptr++;
    if (nwritten < HIST_DEPTH) nwritten++;
    if (pfill >= 8) push_group(0);
    pack |= 64'(v) << (8 * (pfill & 7));
    pfill++;
    if (remain > 0) remain--;
    if (remain == 0) live = 0;
  endfunction

  function automatic void open_field(int n, field_e d);
    fshift = 0;
    fleft = n;
    fdest = d;
    tstate = TK_FIELD;
  endfunction

  function automatic void begin_run(int c);
    if (32'(c) > remain) bad = 1;
    run_len = c;
  endfunction

  function automatic void copy_back(int off);
    bit [7:0] v;
    for (int k = 0; k < run_len && live; k++) begin
      v = 0;
      if (off >= 1 && off <= nwritten && off < HIST_DEPTH) v = hist[hptr - 12'(off)];
      else bad = 1;
      emit_byte(v);
    end
    tstate = TK_PREFIX0;
  endfunction

  function automatic void field_complete();
    int c;
    c = fshift;
    case (fdest)
      F_SELECT: begin
        if (c == 3) open_field(8, F_LITCNT8);
        else if (c < 2) begin
          begin_run(c + 3);
          open_field(c + 9, F_OFFSET);
        end else open_field(8, F_COPYLEN);
      end
      F_LITCNT3: begin
        begin_run(c + 1);
        open_field(8, F_LITERAL);
      end
      F_LITCNT8: begin
        begin_run(c + 9);
        open_field(8, F_LITERAL);
      end
      F_COPYLEN: begin
        begin_run(c + 1);
        open_field(12, F_OFFSET);
      end
      F_OFFSET: copy_back(c);
      default: begin
        emit_byte(c[7:0]);
        if (run_len > 0) run_len--;
        if (run_len == 0) tstate = TK_PREFIX0;
        else open_field(8, F_LITERAL);
      end
    endcase
  endfunction

  function automatic void decode_bit(bit b);
    if (!live) return;
    if (tstate == TK_PREFIX0) begin
      if (!b) tstate = TK_PREFIX1;
      else open_field(2, F_SELECT);
    end else if (tstate == TK_PREFIX1) begin
      if (!b) open_field(3, F_LITCNT3);
      else begin
        begin_run(2);
        open_field(8, F_OFFSET);
      end
    end else begin
      fshift = {fshift[14:0], b};
      if (fleft > 0) fleft--;
      if (fleft == 0) field_complete();
    end
  endfunction

  function automatic void close_unpack();
    push_group(1);
    ustate = ST_IDLE;
    live = 0;
  endfunction

  function automatic void open_unpack();
    ustate = ST_HEADER;
    bpos = 0;
    word_buf = 0;
    chk_acc = 0;
    remain = 0;
    tstate = TK_PREFIX0;
    fshift = 0;
    fleft = 0;
    fdest = F_SELECT;
    run_len = 0;
    hptr = 0;
    nwritten = 0;
    pack = 0;
    pfill = 0;
    live = 0;
    bad = 0;
  endfunction

  function automatic void predict_unpack(bit [7:0] data, bit sof);
    bit [31:0] w;
    step_n = 0;
    if (sof) open_unpack();
    else if (ustate == ST_IDLE) return;
    case (ustate)
      ST_HEADER: begin
        word_buf |= 32'(data) << (8 * (bpos & 3));
        bpos++;
        if (bpos == 4) begin
          remain = word_buf;
          word_buf = 0;
        end else if (bpos == 8) begin
          chk_acc = word_buf;
          word_buf = 0;
        end else if (bpos >= 12) begin
          w = word_buf;
          word_buf = 0;
          chk_acc ^= w;
          ustate = ST_DATA;
          bpos = 0;
          if (remain == 0) begin
            bad = 1;
            close_unpack();
          end else begin
            live = 1;
            for (int i = 0; i < 32 && live; i++) begin
              if ((w >> i) <= 1) break;
              decode_bit(w[i]);
            end
            if (!live) close_unpack();
          end
        end
      end
      ST_DATA: begin
        chk_acc ^= 32'(data) << (8 * bpos);
        for (int i = 0; i < 8 && live; i++) decode_bit(data[i]);
        bpos = (bpos + 1) & 3;
        if (!live) begin
          if (bpos == 0) close_unpack();
          else ustate = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        chk_acc ^= 32'(data) << (8 * bpos);
        bpos = (bpos + 1) & 3;
        if (bpos == 0) close_unpack();
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_byte(bit [7:0] data, bit sof, bit drain_first);
    packed_item_t it;
    it.data = data;
    it.sof = sof;
    it.drain_first = drain_first;
    pending_bytes.push_back(it);
  endfunction

  function automatic void queue_word(bit [31:0] w, ref int left, input bit first);
    for (int i = 0; i < 4; i++) begin
      if (left > 0) queue_byte(w[8*i +: 8], first && i == 0, 0);
      left--;
    end
  endfunction

  // header, marker word and data words; cut truncates the file
  function automatic void build_file(bit [31:0] size, int nwords, int cut, bit drain_first);
    bit [31:0] words[$];
    bit [31:0] marker, chk;
    int top, k, left;
    top = $urandom_range(0, 31);
    marker = $urandom;
    marker = (marker & ((32'h1 << top) - 1)) | (32'h1 << top);
    for (int i = 0; i < nwords; i++) words.push_back($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF :
                                                     $urandom);
    k = $urandom_range(0, nwords);
    chk = marker;
    for (int i = 0; i < k; i++) chk ^= words[i];
    if ($urandom_range(0, 3) == 0) chk = $urandom;
    left = cut;
    queue_word(size, left, 1);
    if (drain_first) pending_bytes[pending_bytes.size() - ((cut >= 4) ? 4 : cut)].drain_first = 1;
    queue_word(chk, left, 0);
    queue_word(marker, left, 0);
    foreach (words[i]) queue_word(words[i], left, 0);
    files_built++;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int r, size, nw, len;
    rst_n = 0;
    push = 0;
    pop = 0;
    in_packed_byte = 0;
    in_start_of_file = 0;
    // idle bytes, zero size, size of one, all-ones size
    queue_byte(8'h00, 0, 0);
    queue_byte(8'hFF, 0, 0);
    build_file(0, 0, 12, 0);
    build_file(1, 1, 16, 0);
    queue_byte(8'hA5, 0, 0);
    build_file(32'hFFFF_FFFF, 2, 20, 1);
    while (pending_bytes.size() < 430) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        repeat ($urandom_range(1, 3)) queue_byte($urandom, 0, 0);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 85) size = $urandom_range(1, 40);
      else if (r < 95) size = $urandom_range(41, 300);
      else size = $urandom;
      nw = (size > 300 || size < 0) ? 12 : size * 10 / 32 + 2;
      len = 12 + 4 * nw;
      if ($urandom_range(0, 99) < 6) len = $urandom_range(1, len - 1);
      build_file(size, nw, len, $urandom_range(0, 7) == 0);
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    wait (pending_bytes.size() == 0 && accepted == issued);
    wait (expected_groups.size() == 0);
    repeat (2000) @(posedge clk);
    $display("%0d packed bytes over %0d files sent, %0d result transactions, %0d final",
             accepted, files_built, groups_seen, finals_seen);
    if (mismatches == 0 && expected_groups.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!push || accepted == issued) begin
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        if (send_gap > 0) begin
          send_gap--;
          push <= 0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain_first && expected_groups.size() != 0)) begin
          in_packed_byte <= pending_bytes[0].data;
          in_start_of_file <= pending_bytes[0].sof;
          void'(pending_bytes.pop_front());
          push <= 1;
          issued++;
          send_gap = pick_gap(send_burst);
        end else begin
          push <= 0;
        end
      end
      if ($urandom_range(0, 63) == 0) pop_burst = !pop_burst;
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 0;
      end else begin
        pop <= 1;
        pop_gap = pick_gap(pop_burst);
      end
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (push && !full) begin
        predict_unpack(in_packed_byte, in_start_of_file);
        accepted++;
      end
      if (pop && !empty) begin
        groups_seen++;
        if (out_final_group) finals_seen++;
        if (expected_groups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: bytes=%h count=%0d final=%b",
                     out_bytes, out_byte_count, out_final_group);
        end else begin
          e = expected_groups.pop_front();
          if (out_bytes !== e.bytes || out_byte_count !== e.count ||
              out_final_group !== e.final_grp || out_check_ok !== e.chk ||
              out_malformed !== e.bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: exp bytes=%h cnt=%0d fin=%b chk=%b bad=%b, got %h %0d %b %b %b",
                       groups_seen, e.bytes, e.count, e.final_grp, e.chk, e.bad,
                       out_bytes, out_byte_count, out_final_group, out_check_ok,
                       out_malformed);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### backward_lz_bitstream_unpacker.f
+incdir+rtl/core
rtl/core/blbu_pkg.sv
rtl/core/blbu_fifo.sv
rtl/core/blbu_front.sv
rtl/core/blbu_back.sv
rtl/core/backward_lz_bitstream_unpacker.sv
dv/tb_top.sv
